[rtl/core/cus_pkg.sv]
// ----------------------------------------------------------------------------
// cus_pkg
// Shared types, codes and sizes of the chunked upload sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cus_pkg;

  // job ring sizing
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVEL_W     = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_LIMIT = 1'b1;
  localparam logic [15:0] CHUNK_SIZE_RST  = 16'd256;
  localparam logic [15:0] REPLY_LIMIT_RST = 16'd5000;

  // request codes
  localparam logic [2:0] REQ_ENQUEUE = 3'd0;
  localparam logic [2:0] REQ_RUN     = 3'd1;
  localparam logic [2:0] REQ_PREPARE = 3'd2;
  localparam logic [2:0] REQ_ACK     = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  // message kinds
  localparam logic [1:0] MSG_NONE  = 2'd0;
  localparam logic [1:0] MSG_BEGIN = 2'd1;
  localparam logic [1:0] MSG_PIECE = 2'd2;

  // completion codes
  localparam logic [1:0] CPL_NONE = 2'd0;
  localparam logic [1:0] CPL_OK   = 2'd1;
  localparam logic [1:0] CPL_FAIL = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_QUEUE_FULL = 3'd1;
  localparam logic [2:0] ERR_SIZE_ZERO  = 3'd2;
  localparam logic [2:0] ERR_NACK       = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT    = 3'd4;

  // transfer phases
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_COMPUTE    = 3'd1,
    PH_SEND_BEGIN = 3'd2,
    PH_WAIT_BEGIN = 3'd3,
    PH_SEND_PIECE = 3'd4,
    PH_WAIT_PIECE = 3'd5,
    PH_FINALIZE   = 3'd6,
    PH_CLEANUP    = 3'd7
  } cus_phase_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  job_id;
    logic [31:0] job_size;
    logic        ack_ok;
  } cus_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] size;
  } cus_entry_t;

  // commands into the job ring
  typedef struct packed {
    logic       push;
    logic       pop;
    cus_entry_t entry;
  } cus_qcmd_t;

  // status out of the job ring
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    cus_entry_t        head;
  } cus_qstat_t;

  typedef struct packed {
    logic               accepted;
    logic [1:0]         msg_kind;
    logic [7:0]         msg_job_id;
    logic [31:0]        msg_file_size;
    logic [31:0]        msg_piece_index;
    logic [31:0]        msg_offset;
    logic [15:0]        msg_length;
    logic [1:0]         complete;
    logic [2:0]         error_code;
    logic [LEVEL_W-1:0] queue_level;
  } cus_result_t;

endpackage

`default_nettype wire

[rtl/core/cus_queue.sv]
// ----------------------------------------------------------------------------
// cus_queue
// Ring of pending upload jobs: push at the tail, pop at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module cus_queue import cus_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cus_qcmd_t  cmd,
  output cus_qstat_t      stat
);

  cus_entry_t        store [QUEUE_DEPTH];
  cus_entry_t        head_ent_r;
  logic [QPTR_W-1:0] head_r;
  logic [QPTR_W-1:0] head_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic [QPTR_W:0]   tail_sum;
  logic [QPTR_W-1:0] tail;

  // tail = (head + count) mod depth, sum stays below twice the depth
  always_comb begin
    tail_sum = (QPTR_W+1)'(head_r) + (QPTR_W+1)'(count_r);
    if (tail_sum >= (QPTR_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QPTR_W+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[QPTR_W-1:0];
  end

  // pointer and fill count
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[tail] <= cmd.entry;
    end
  end

  // head entry read ahead for the next cycle, a push into the head slot passes through
  always_ff @(posedge clk) begin
    if (cmd.push && (tail == head_nxt)) begin
      head_ent_r <= cmd.entry;
    end else begin
      head_ent_r <= store[head_nxt];
    end
  end

  assign stat.count = count_r;
  assign stat.head  = head_ent_r;

endmodule

`default_nettype wire

[rtl/core/cus_ctrl.sv]
// ----------------------------------------------------------------------------
// cus_ctrl
// Transfer phase machine, current job state and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module cus_ctrl import cus_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  fire,
  input  wire cus_item_t             item,
  input  wire cus_qstat_t            qstat,
  output cus_qcmd_t                  qcmd,
  output cus_result_t                result
);

  logic [15:0] chunk_size_r;
  logic [15:0] reply_limit_r;

  cus_phase_t  phase_r,      phase_nxt;
  logic [7:0]  cur_id_r,     cur_id_nxt;
  logic [31:0] cur_size_r,   cur_size_nxt;
  logic [31:0] cur_offset_r, cur_offset_nxt;
  logic [31:0] piece_cnt_r,  piece_cnt_nxt;
  logic [15:0] wait_ticks_r, wait_ticks_nxt;

  logic [15:0]       cs_eff;
  logic [31:0]       remain;
  logic              last_piece;
  logic [15:0]       piece_len;
  logic              timed_out;
  logic [QCNT_W-1:0] level;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r  <= CHUNK_SIZE_RST;
      reply_limit_r <= REPLY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNK_SIZE:  chunk_size_r  <= cfg_data;
        CFG_REPLY_LIMIT: reply_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // piece length: a zero chunk size counts as one
  always_comb begin
    cs_eff     = (chunk_size_r == 16'd0) ? 16'd1 : chunk_size_r;
    remain     = cur_size_r - cur_offset_r;
    last_piece = (remain <= {16'd0, cs_eff});
    piece_len  = last_piece ? remain[15:0] : cs_eff;
    timed_out  = ((phase_r == PH_WAIT_BEGIN) || (phase_r == PH_WAIT_PIECE)) &&
                 (wait_ticks_r >= reply_limit_r);
  end

  // next state and result
  always_comb begin
    phase_nxt      = phase_r;
    cur_id_nxt     = cur_id_r;
    cur_size_nxt   = cur_size_r;
    cur_offset_nxt = cur_offset_r;
    piece_cnt_nxt  = piece_cnt_r;
    wait_ticks_nxt = wait_ticks_r;
    result         = '0;
    qcmd.push      = 1'b0;
    qcmd.pop       = 1'b0;
    qcmd.entry.id   = item.job_id;
    qcmd.entry.size = item.job_size;

    if (fire) begin
      case (item.req_type)
        REQ_ENQUEUE: begin
          if (item.job_size == 32'd0) begin
            result.error_code = ERR_SIZE_ZERO;
          end else if (qstat.count >= QCNT_W'(QUEUE_DEPTH)) begin
            result.error_code = ERR_QUEUE_FULL;
          end else begin
            qcmd.push       = 1'b1;
            result.accepted = 1'b1;
          end
        end
        REQ_RUN: begin
          if (timed_out) begin
            // a timeout fails the job on the same run beat
            result.error_code = ERR_TIMEOUT;
            result.complete   = CPL_FAIL;
            phase_nxt         = PH_IDLE;
          end else begin
            case (phase_r)
              PH_IDLE: begin
                if (qstat.count != '0) begin
                  qcmd.pop       = 1'b1;
                  cur_id_nxt     = qstat.head.id;
                  cur_size_nxt   = qstat.head.size;
                  cur_offset_nxt = '0;
                  piece_cnt_nxt  = '0;
                  phase_nxt      = PH_COMPUTE;
                end
              end
              PH_COMPUTE: phase_nxt = PH_SEND_BEGIN;
              PH_FINALIZE: begin
                result.complete = CPL_OK;
                phase_nxt       = PH_IDLE;
              end
              PH_CLEANUP: begin
                result.complete = CPL_FAIL;
                phase_nxt       = PH_IDLE;
              end
              default: ;
            endcase
          end
        end
        REQ_PREPARE: begin
          if (phase_r == PH_SEND_BEGIN) begin
            result.msg_kind      = MSG_BEGIN;
            result.msg_job_id    = cur_id_r;
            result.msg_file_size = cur_size_r;
            phase_nxt            = PH_WAIT_BEGIN;
            wait_ticks_nxt       = '0;
          end else if (phase_r == PH_SEND_PIECE) begin
            result.msg_kind        = MSG_PIECE;
            result.msg_job_id      = cur_id_r;
            result.msg_piece_index = piece_cnt_r;
            result.msg_offset      = cur_offset_r;
            result.msg_length      = piece_len;
            phase_nxt              = PH_WAIT_PIECE;
            wait_ticks_nxt         = '0;
          end
        end
        REQ_ACK: begin
          if (!item.ack_ok) begin
            // nack aborts anything but idle
            if (phase_r != PH_IDLE) begin
              result.error_code = ERR_NACK;
              phase_nxt         = PH_CLEANUP;
            end
          end else if (phase_r == PH_WAIT_BEGIN) begin
            phase_nxt = PH_SEND_PIECE;
          end else if (phase_r == PH_WAIT_PIECE) begin
            cur_offset_nxt = cur_offset_r + {16'd0, piece_len};
            piece_cnt_nxt  = piece_cnt_r + 32'd1;
            phase_nxt      = last_piece ? PH_FINALIZE : PH_SEND_PIECE;
          end
        end
        REQ_TICK: begin
          if (wait_ticks_r != 16'hFFFF) begin
            wait_ticks_nxt = wait_ticks_r + 16'd1;
          end
        end
        default: ;
      endcase
    end

    // queue level after this beat
    level = qstat.count;
    if (qcmd.push) begin
      level = qstat.count + 1'b1;
    end else if (qcmd.pop) begin
      level = qstat.count - 1'b1;
    end
    result.queue_level = LEVEL_W'(level);
  end

  // job state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cur_id_r     <= '0;
      cur_size_r   <= '0;
      cur_offset_r <= '0;
      piece_cnt_r  <= '0;
      wait_ticks_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      cur_id_r     <= cur_id_nxt;
      cur_size_r   <= cur_size_nxt;
      cur_offset_r <= cur_offset_nxt;
      piece_cnt_r  <= piece_cnt_nxt;
      wait_ticks_r <= wait_ticks_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/chunked_upload_sequencer.sv]
// ----------------------------------------------------------------------------
// chunked_upload_sequencer
// Job ring plus stop-and-wait transfer sequencer, one result per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_*      input      in_valid/in_ready  req_type, job_id, job_size, ack_ok
//  out_*     output     out_valid/out_ready one result beat per request beat
//  cfg_*     input      cfg_we             cfg_index, cfg_data (16 bit)
//
//  one request beat per cycle while out_ready holds; each beat passes the input
//  register, then the phase machine and job ring update into the result register
//  the result register sets the figure: a beat leaves it only when out_ready
//  a stalled result still lets one more request into the input register
//  reset (rst_n low, synchronous) empties the ring and returns to idle
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_upload_sequencer import cus_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_req_type,
  input  wire logic [7:0]            in_job_id,
  input  wire logic [31:0]           in_job_size,
  input  wire logic                  in_ack_ok,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_accepted,
  output logic [1:0]                 out_msg_kind,
  output logic [7:0]                 out_msg_job_id,
  output logic [31:0]                out_msg_file_size,
  output logic [31:0]                out_msg_piece_index,
  output logic [31:0]                out_msg_offset,
  output logic [15:0]                out_msg_length,
  output logic [1:0]                 out_complete,
  output logic [2:0]                 out_error_code,
  output logic [LEVEL_W-1:0]         out_queue_level,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic        in_vld_r;
  cus_item_t   item_r;
  logic        out_vld_r;
  cus_result_t res_r;
  cus_result_t res_nxt;
  logic        advance;
  logic        fire;
  cus_qcmd_t   qcmd;
  cus_qstat_t  qstat;

  // pipeline control
  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req_type <= in_req_type;
      item_r.job_id   <= in_job_id;
      item_r.job_size <= in_job_size;
      item_r.ack_ok   <= in_ack_ok;
    end
  end

  cus_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (qcmd),
    .stat  (qstat)
  );

  cus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item_r),
    .qstat     (qstat),
    .qcmd      (qcmd),
    .result    (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_accepted        = res_r.accepted;
  assign out_msg_kind        = res_r.msg_kind;
  assign out_msg_job_id      = res_r.msg_job_id;
  assign out_msg_file_size   = res_r.msg_file_size;
  assign out_msg_piece_index = res_r.msg_piece_index;
  assign out_msg_offset      = res_r.msg_offset;
  assign out_msg_length      = res_r.msg_length;
  assign out_complete        = res_r.complete;
  assign out_error_code      = res_r.error_code;
  assign out_queue_level     = res_r.queue_level;

endmodule

`default_nettype wire

[rtl/core/cus_checker.sv]
// ----------------------------------------------------------------------------
// cus_checker
// Port-level checks of the chunked upload sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cus_checker import cus_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_accepted,
  input wire logic [1:0]            out_msg_kind,
  input wire logic [1:0]            out_complete,
  input wire logic [2:0]            out_error_code,
  input wire logic [LEVEL_W-1:0]    out_queue_level
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_error_code) && $stable(out_queue_level))
    else $error("result beat changed while stalled");

  // a message beat carries no completion or enqueue status
  a_msg_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_msg_kind != MSG_NONE) |->
      (out_complete == CPL_NONE) && !out_accepted && (out_error_code == ERR_NONE))
    else $error("message beat mixed with other status");

  // a timeout always fails the job on the same beat
  a_timeout_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_TIMEOUT) |-> (out_complete == CPL_FAIL))
    else $error("timeout without failure report");

  // an accepted job leaves the ring non-empty and within depth
  a_accept_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |->
      (out_queue_level != '0) && (out_queue_level <= LEVEL_W'(QUEUE_DEPTH)) &&
      (out_error_code == ERR_NONE))
    else $error("accepted job with bad queue level");

endmodule

bind chunked_upload_sequencer cus_checker u_cus_checker (.*);

`default_nettype wire

[verif/cus_upload_tracker_pkg.sv]
// ----------------------------------------------------------------------------
// cus_upload_tracker_pkg
// Mirror of the upload sequencer's job ring and transfer phase. Each request
// beat taken by the block is stepped through the mirror, and the reply that
// the block owes for it is queued. Result beats are checked in order against
// the queue.
// ----------------------------------------------------------------------------
package cus_upload_tracker_pkg;
  import cus_pkg::*;

  class upload_tracker;
    // job ring mirror
    bit [7:0]    ring_id[QUEUE_DEPTH];
    bit [31:0]   ring_size[QUEUE_DEPTH];
    int unsigned head;
    int unsigned count;
    // job in transfer
    bit [7:0]    cur_id;
    bit [31:0]   cur_size;
    bit [31:0]   cur_offset;
    bit [31:0]   piece_no;
    cus_phase_t  phase;
    bit [15:0]   wait_ticks;
    // register copies
    bit [15:0]   chunk_size;
    bit [15:0]   reply_limit;
    // replies owed by the block, oldest first
    cus_result_t replies_due[$];
    int unsigned beats_seen;
    int unsigned fail_count;

    function new();
      head        = 0;
      count       = 0;
      cur_id      = '0;
      cur_size    = '0;
      cur_offset  = '0;
      piece_no    = '0;
      phase       = PH_IDLE;
      wait_ticks  = '0;
      chunk_size  = CHUNK_SIZE_RST;
      reply_limit = REPLY_LIMIT_RST;
      beats_seen  = 0;
      fail_count  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_CHUNK_SIZE:  chunk_size = data;
        CFG_REPLY_LIMIT: reply_limit = data;
        default: ;
      endcase
    endfunction

    // bytes in the next piece; a zero chunk size counts as one byte
    function bit [31:0] piece_bytes();
      bit [31:0] unit;
      bit [31:0] rest;
      unit = (chunk_size == 0) ? 32'd1 : {16'd0, chunk_size};
      rest = cur_size - cur_offset;
      return (rest >= unit) ? unit : rest;
    endfunction

    // step the mirror by one accepted request and queue the reply it owes
    function void note_request(cus_item_t it);
      cus_result_t r;
      r = '0;
      case (it.req_type)
        REQ_ENQUEUE: begin
          // size zero wins over a full ring
          if (it.job_size == 0) begin
            r.error_code = ERR_SIZE_ZERO;
          end else if (count >= QUEUE_DEPTH) begin
            r.error_code = ERR_QUEUE_FULL;
          end else begin
            ring_id[(head + count) % QUEUE_DEPTH]   = it.job_id;
            ring_size[(head + count) % QUEUE_DEPTH] = it.job_size;
            count++;
            r.accepted = 1'b1;
          end
        end
        REQ_RUN: begin
          // timeout only seen by a run while waiting; it fails on this same run
          if ((phase == PH_WAIT_BEGIN || phase == PH_WAIT_PIECE) &&
              wait_ticks >= reply_limit) begin
            r.error_code = ERR_TIMEOUT;
            phase        = PH_CLEANUP;
          end
          case (phase)
            PH_IDLE: begin
              if (count > 0) begin
                cur_id     = ring_id[head];
                cur_size   = ring_size[head];
                head       = (head + 1) % QUEUE_DEPTH;
                count--;
                cur_offset = '0;
                piece_no   = '0;
                phase      = PH_COMPUTE;
              end
            end
            PH_COMPUTE: phase = PH_SEND_BEGIN;
            PH_FINALIZE: begin
              r.complete = CPL_OK;
              phase      = PH_IDLE;
            end
            PH_CLEANUP: begin
              r.complete = CPL_FAIL;
              phase      = PH_IDLE;
            end
            default: ;
          endcase
        end
        REQ_PREPARE: begin
          if (phase == PH_SEND_BEGIN) begin
            r.msg_kind      = MSG_BEGIN;
            r.msg_job_id    = cur_id;
            r.msg_file_size = cur_size;
            phase           = PH_WAIT_BEGIN;
            wait_ticks      = '0;
          end else if (phase == PH_SEND_PIECE) begin
            r.msg_kind        = MSG_PIECE;
            r.msg_job_id      = cur_id;
            r.msg_piece_index = piece_no;
            r.msg_offset      = cur_offset;
            r.msg_length      = 16'(piece_bytes());
            phase             = PH_WAIT_PIECE;
            wait_ticks        = '0;
          end
        end
        REQ_ACK: begin
          if (!it.ack_ok) begin
            // a nack aborts anything but idle
            if (phase != PH_IDLE) begin
              r.error_code = ERR_NACK;
              phase        = PH_CLEANUP;
            end
          end else if (phase == PH_WAIT_BEGIN) begin
            phase = PH_SEND_PIECE;
          end else if (phase == PH_WAIT_PIECE) begin
            cur_offset += piece_bytes();
            piece_no++;
            phase = (cur_offset >= cur_size) ? PH_FINALIZE : PH_SEND_PIECE;
          end
        end
        REQ_TICK: begin
          if (wait_ticks != 16'hFFFF) wait_ticks++;
        end
        default: ;
      endcase
      r.queue_level = LEVEL_W'(count);
      replies_due.push_back(r);
    endfunction

    function string show(cus_result_t r);
      return $sformatf({"acc=%0d kind=%0d id=%02h fsize=%0d piece=%0d off=%0d len=%0d ",
                        "cpl=%0d err=%0d lvl=%0d"},
                       r.accepted, r.msg_kind, r.msg_job_id, r.msg_file_size,
                       r.msg_piece_index, r.msg_offset, r.msg_length, r.complete,
                       r.error_code, r.queue_level);
    endfunction

    // compare one result beat with the oldest owed reply
    function void check_reply(cus_result_t got);
      cus_result_t want;
      string       bad;
      beats_seen++;
      if (replies_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result beat %0d with no request behind it: %s",
                                       beats_seen, show(got));
        return;
      end
      want = replies_due.pop_front();
      bad  = "";
      if (got.accepted !== want.accepted)               bad = {bad, " accepted"};
      if (got.msg_kind !== want.msg_kind)               bad = {bad, " msg_kind"};
      if (got.msg_job_id !== want.msg_job_id)           bad = {bad, " msg_job_id"};
      if (got.msg_file_size !== want.msg_file_size)     bad = {bad, " msg_file_size"};
      if (got.msg_piece_index !== want.msg_piece_index) bad = {bad, " msg_piece_index"};
      if (got.msg_offset !== want.msg_offset)           bad = {bad, " msg_offset"};
      if (got.msg_length !== want.msg_length)           bad = {bad, " msg_length"};
      if (got.complete !== want.complete)               bad = {bad, " complete"};
      if (got.error_code !== want.error_code)           bad = {bad, " error_code"};
      if (got.queue_level !== want.queue_level)         bad = {bad, " queue_level"};
      if (bad != "") begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result beat %0d wrong in%s", beats_seen, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

[verif/tb_chunked_upload_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_chunked_upload_sequencer
// Drives request beats into the upload sequencer and checks every result beat
// against a mirror of the job ring and transfer phase. A short directed part
// covers rejects, out-of-turn requests, one full job and one nacked job; then phases under
// different chunk and timeout settings run mostly well-formed transfers with
// random sizes, ticks, nacks and noise, a tick run past the timeout, and one
// long result stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_chunked_upload_sequencer import cus_pkg::*, cus_upload_tracker_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned LATE_TICKS    = 24;
  localparam logic [15:0] SHORT_LIMIT   = 16'd20;
  localparam int unsigned HOLD_CYCLES   = 48;
  localparam int unsigned PHASE_ITEMS   = 72;
  localparam int unsigned QUIET_TAIL    = 40;
  localparam logic [2:0]  REQ_UNUSED    = 3'd5;
  localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            in_req_type = REQ_TICK;
  logic [7:0]            in_job_id = '0;
  logic [31:0]           in_job_size = '0;
  logic                  in_ack_ok = 1'b0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_accepted;
  logic [1:0]            out_msg_kind;
  logic [7:0]            out_msg_job_id;
  logic [31:0]           out_msg_file_size;
  logic [31:0]           out_msg_piece_index;
  logic [31:0]           out_msg_offset;
  logic [15:0]           out_msg_length;
  logic [1:0]            out_complete;
  logic [2:0]            out_error_code;
  logic [LEVEL_W-1:0]    out_queue_level;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CHUNK_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  upload_tracker tracker = new();
  int unsigned   idle_pct = 20;
  int unsigned   stall_left = 0;
  int unsigned   cycle_count = 0;
  bit            hold_req = 1'b0;
  bit            hold_active = 1'b0;

  chunked_upload_sequencer dut (.*);

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check each beat, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_reply({out_accepted, out_msg_kind, out_msg_job_id, out_msg_file_size,
                           out_msg_piece_index, out_msg_offset, out_msg_length,
                           out_complete, out_error_code, out_queue_level});
    end
    if (hold_req) begin
      hold_req    = 1'b0;
      hold_active = 1'b1;
      stall_left  = HOLD_CYCLES;
    end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 8);
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready   <= 1'b1;
      hold_active = 1'b0;
    end
  end

  function automatic cus_item_t mk(logic [2:0] req, logic [7:0] id, logic [31:0] size,
                                   logic ok);
    cus_item_t it;
    it.req_type = req;
    it.job_id   = id;
    it.job_size = size;
    it.ack_ok   = ok;
    return it;
  endfunction

  // job sizes mostly a few pieces long at the current chunk size
  function automatic logic [31:0] job_bytes();
    int unsigned unit;
    int unsigned pick;
    unit = (tracker.chunk_size == 0) ? 1 : tracker.chunk_size;
    pick = $urandom_range(0, 15);
    if (pick == 0) return $urandom;
    if (pick == 1) return '0;
    if (pick < 4) return unit * $urandom_range(1, 4);
    return $urandom_range(1, 4 * unit);
  endfunction

  // next request: what the current phase wants, now and then a stray one
  function automatic cus_item_t pick_next(bit noise);
    cus_item_t   it;
    int unsigned roll;
    it = mk(REQ_RUN, 8'($urandom), job_bytes(), 1'b1);
    roll = $urandom_range(0, 99);
    if (noise) begin
      it.req_type = 3'($urandom);
      it.job_size = $urandom;
      it.ack_ok   = 1'($urandom);
    end else begin
      case (tracker.phase)
        PH_IDLE: begin
          if (tracker.count == 0 ||
              roll < ((tracker.count < QUEUE_DEPTH) ? 45 : 8)) it.req_type = REQ_ENQUEUE;
        end
        PH_SEND_BEGIN, PH_SEND_PIECE: begin
          it.req_type = (roll < 8) ? REQ_ENQUEUE : REQ_PREPARE;
        end
        PH_WAIT_BEGIN, PH_WAIT_PIECE: begin
          if (roll < 25) begin
            it.req_type = REQ_TICK;
          end else if (roll >= 33) begin
            it.req_type = REQ_ACK;
            it.ack_ok   = (roll >= 37);
          end
        end
        default: begin
          if (roll < 8) begin
            it.req_type = REQ_ACK;
            it.ack_ok   = (roll >= 4);
          end
        end
      endcase
    end
    return it;
  endfunction

  // offer one beat, hold it until taken, then maybe idle a burst
  task automatic push_request(input cus_item_t it);
    int unsigned gap;
    in_valid    <= 1'b1;
    in_req_type <= it.req_type;
    in_job_id   <= it.job_id;
    in_job_size <= it.job_size;
    in_ack_ok   <= it.ack_ok;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(it);
    if (idle_pct != 0 && !hold_req && !hold_active && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.replies_due.size() != 0);
  endtask

  // both registers, written once the block has nothing in flight
  task automatic set_config(input logic [15:0] chunk, input logic [15:0] ticks);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHUNK_SIZE;
    cfg_data  <= chunk;
    @(posedge clk);
    tracker.write_reg(CFG_CHUNK_SIZE, chunk);
    cfg_index <= CFG_REPLY_LIMIT;
    cfg_data  <= ticks;
    @(posedge clk);
    tracker.write_reg(CFG_REPLY_LIMIT, ticks);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // well-formed requests until the count is reached; noise does not count
  task automatic run_random(input int unsigned n_items);
    int unsigned made;
    bit          noise;
    made = 0;
    while (made < n_items) begin
      noise = ($urandom_range(0, 99) < 12);
      push_request(pick_next(noise));
      if (!noise) made++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring: size zero, out-of-turn run, prepare and acks, unknown codes
    push_request(mk(REQ_ENQUEUE, 8'hFF, 32'd0, 1'b1));
    push_request(mk(REQ_RUN, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_PREPARE, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_ACK, 8'h00, 32'd0, 1'b1));
    push_request(mk(REQ_ACK, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1));
    push_request(mk(REQ_UNUSED_HI, 8'h00, 32'd0, 1'b0));

    // fill the ring, then push past it with and without a size
    push_request(mk(REQ_ENQUEUE, 8'h00, 32'd1, 1'b0));
    push_request(mk(REQ_ENQUEUE, 8'h01, 32'd256, 1'b1));
    push_request(mk(REQ_ENQUEUE, 8'h80, 32'd257, 1'b0));
    push_request(mk(REQ_ENQUEUE, 8'h55, 32'd512, 1'b1));
    push_request(mk(REQ_ENQUEUE, 8'hAA, 32'hFFFF_FFFF, 1'b0));
    push_request(mk(REQ_ENQUEUE, 8'h7F, 32'h8000_0000, 1'b1));
    push_request(mk(REQ_ENQUEUE, 8'hFE, 32'd3, 1'b0));
    push_request(mk(REQ_ENQUEUE, 8'hFF, 32'd1000, 1'b1));
    push_request(mk(REQ_ENQUEUE, 8'h42, 32'd7, 1'b1));
    push_request(mk(REQ_ENQUEUE, 8'h43, 32'd0, 1'b1));

    // one-byte job start to finish
    push_request(mk(REQ_RUN, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_RUN, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_PREPARE, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_ACK, 8'h00, 32'd0, 1'b1));
    push_request(mk(REQ_PREPARE, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_ACK, 8'h00, 32'd0, 1'b1));
    push_request(mk(REQ_RUN, 8'h00, 32'd0, 1'b0));

    // next job aborted by a nack before its begin message
    push_request(mk(REQ_RUN, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_ACK, 8'h00, 32'd0, 1'b0));
    push_request(mk(REQ_RUN, 8'h00, 32'd0, 1'b0));

    // smallest pieces, shortest timeout
    set_config(16'd1, 16'd1);
    idle_pct = 20;
    run_random(PHASE_ITEMS);

    // largest chunk size: ticks run past a short limit, then a run times out
    set_config(16'hFFFF, SHORT_LIMIT);
    idle_pct = 0;
    while (tracker.phase != PH_WAIT_BEGIN && tracker.phase != PH_WAIT_PIECE) begin
      push_request(pick_next(1'b0));
    end
    repeat (LATE_TICKS) push_request(mk(REQ_TICK, 8'($urandom), $urandom, 1'($urandom)));
    push_request(mk(REQ_RUN, 8'h00, 32'd0, 1'b0));

    // long result stall while requests keep coming
    idle_pct = 35;
    hold_req = 1'b1;
    run_random(PHASE_ITEMS);

    // zero chunk size acts as one byte
    set_config(16'd0, 16'd2);
    idle_pct = 50;
    run_random(PHASE_ITEMS);

    set_config(16'($urandom_range(2, 48)), 16'($urandom_range(1, 16)));
    idle_pct = 10;
    run_random(PHASE_ITEMS);

    // last stretch with idles, then a tail that runs flat out
    set_config(16'($urandom_range(1, 300)), 16'($urandom_range(1, 8)));
    idle_pct = 25;
    run_random(PHASE_ITEMS - QUIET_TAIL);
    idle_pct = 0;
    run_random(QUIET_TAIL);

    wait_drained();
    repeat (4) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.replies_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[chunked_upload_sequencer.f]
rtl/core/cus_pkg.sv
rtl/core/cus_queue.sv
rtl/core/cus_ctrl.sv
rtl/core/chunked_upload_sequencer.sv
rtl/core/cus_checker.sv
verif/cus_upload_tracker_pkg.sv
verif/tb_chunked_upload_sequencer.sv
